// ----- rtl/asse_pkg.sv -----
package asse_pkg;

  localparam logic [1:0] REQ_OP  = 2'd0;
  localparam logic [1:0] REQ_GET = 2'd1;
  localparam logic [1:0] REQ_SET = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_WAIT        = 3'd1;
  localparam logic [2:0] ST_WOULD_BLOCK = 3'd2;
  localparam logic [2:0] ST_RANGE       = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX   = 3'd4;
  localparam logic [2:0] ST_TOO_MANY    = 3'd5;

  localparam logic [1:0] WK_NONE     = 2'd0;
  localparam logic [1:0] WK_ZERO     = 2'd1;
  localparam logic [1:0] WK_INCREASE = 2'd2;

  localparam int unsigned VAL_W = 15;
  localparam logic [16:0] SEM_VALUE_MAX = 17'h07000;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_OP    = 8'b0000_0100,
    S_GET   = 8'b0000_1000,
    S_FIN   = 8'b0001_0000,
    S_WLOG  = 8'b0010_0000,
    S_WSH   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [2:0]       status;
    logic [1:0]       wait_kind;
    logic [VAL_W-1:0] value;
  } result_t;

endpackage

// ----- rtl/asse_ram.sv -----
module asse_ram #(
  parameter int unsigned W  = 16,
  parameter int unsigned D  = 512,
  parameter int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/atomic_semaphore_set_engine.sv -----
// Channel   Dir  Handshake                    Payload
// in        in   in_valid_i / in_stall_o      req_type, sem_index, op_delta, no_wait,
//                                             last_op, set_value
// out       out  out_valid_o / out_stall_i    status, wait_kind, read_value
// num_sems  in   num_sems_we_i                num_sems_i
//
// After reset a clearing pass zeroes the set; no item is taken.
// Batch element: memory read, then modify and write back; only the read when skipped
// (bad index, batch too long or batch already failed). Get: read, then S_GET; set: write.
// Last element adds S_FIN, then S_WLOG and S_WSH per touched semaphore and a closing
// S_WLOG if any (log walk), then S_EMIT to load the output register, as get and set also end.
// A full output register only holds the block when the next result is due.
module atomic_semaphore_set_engine import asse_pkg::*; #(
  parameter int unsigned MAX_SEMS_PER_SET  = 512,
  parameter int unsigned MAX_OPS_PER_BATCH = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               num_sems_we_i,
  input  logic [9:0]         num_sems_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [9:0]         sem_index_i,
  input  logic signed [15:0] op_delta_i,
  input  logic               no_wait_i,
  input  logic               last_op_i,
  input  logic [15:0]        set_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [1:0]         wait_kind_o,
  output logic [14:0]        read_value_o
);

  localparam int unsigned SW  = (MAX_SEMS_PER_SET > 1) ? $clog2(MAX_SEMS_PER_SET) : 1;
  localparam int unsigned CW  = $clog2(MAX_SEMS_PER_SET + 1);
  localparam int unsigned OCW = $clog2(MAX_OPS_PER_BATCH + 2);

  state_e state_q, state_d;
  logic [9:0] num_sems_q;
  logic [CW-1:0] clr_q, clr_d;
  logic [SW-1:0] idx_q, idx_d, walk_sem_q, walk_sem_d;
  logic signed [15:0] delta_q, delta_d;
  logic nowait_q, nowait_d, last_q, last_d;
  logic [OCW-1:0] op_cnt_q, op_cnt_d, op_inc;
  logic [2:0] outcome_q, outcome_d;
  logic [1:0] wk_q, wk_d;
  logic bad_q, bad_d, commit_q, commit_d;
  logic [CW-1:0] log_cnt_q, log_cnt_d, walk_q, walk_d;
  result_t res_q, res_d, out_q;
  logic out_valid_q;
  logic emit;

  logic sem_we, sh_we, log_we;
  logic [SW-1:0] sem_wa, sh_wa, sh_ra, log_wa, in_idx;
  logic [VAL_W-1:0] sem_wd, sem_rd;
  logic [VAL_W:0] sh_wd, sh_rd;
  logic [SW-1:0] log_rd;
  logic [VAL_W-1:0] cur;
  logic signed [16:0] sum;
  logic idx_ok, accept;

  assign in_idx = SW'(sem_index_i);
  assign idx_ok = (sem_index_i < num_sems_q) && (32'(sem_index_i) < 32'(MAX_SEMS_PER_SET));
  assign in_stall_o = (state_q != S_IDLE);
  assign accept = in_valid_i && (state_q == S_IDLE);
  assign cur = sh_rd[VAL_W] ? sh_rd[VAL_W-1:0] : sem_rd;
  assign sum = $signed({2'b00, cur}) + $signed({delta_q[15], delta_q});
  assign op_inc = (op_cnt_q <= OCW'(MAX_OPS_PER_BATCH)) ? op_cnt_q + 1'b1 : op_cnt_q;

  asse_ram #(.W(VAL_W), .D(MAX_SEMS_PER_SET), .AW(SW)) u_sem (
    .clk_i, .we_i(sem_we), .waddr_i(sem_wa), .wdata_i(sem_wd),
    .raddr_i(in_idx), .rdata_o(sem_rd)
  );

  asse_ram #(.W(VAL_W + 1), .D(MAX_SEMS_PER_SET), .AW(SW)) u_shadow (
    .clk_i, .we_i(sh_we), .waddr_i(sh_wa), .wdata_i(sh_wd),
    .raddr_i(sh_ra), .rdata_o(sh_rd)
  );

  asse_ram #(.W(SW), .D(MAX_SEMS_PER_SET), .AW(SW)) u_log (
    .clk_i, .we_i(log_we), .waddr_i(log_wa), .wdata_i(idx_q),
    .raddr_i(walk_q[SW-1:0]), .rdata_o(log_rd)
  );

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    idx_d      = idx_q;
    delta_d    = delta_q;
    nowait_d   = nowait_q;
    last_d     = last_q;
    op_cnt_d   = op_cnt_q;
    outcome_d  = outcome_q;
    wk_d       = wk_q;
    bad_d      = bad_q;
    commit_d   = commit_q;
    log_cnt_d  = log_cnt_q;
    walk_d     = walk_q;
    walk_sem_d = walk_sem_q;
    res_d      = res_q;
    emit       = 1'b0;
    sem_we     = 1'b0;
    sem_wa     = in_idx;
    sem_wd     = set_value_i[VAL_W-1:0];
    sh_we      = 1'b0;
    sh_wa      = idx_q;
    sh_wd      = {1'b1, sum[VAL_W-1:0]};
    sh_ra      = (state_q == S_WSH) ? log_rd : in_idx;
    log_we     = 1'b0;
    log_wa     = log_cnt_q[SW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        sem_we = 1'b1;
        sem_wa = clr_q[SW-1:0];
        sem_wd = '0;
        sh_we  = 1'b1;
        sh_wa  = clr_q[SW-1:0];
        sh_wd  = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == CW'(MAX_SEMS_PER_SET - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          idx_d    = in_idx;
          delta_d  = op_delta_i;
          nowait_d = no_wait_i;
          last_d   = last_op_i;
          res_d    = '{status: ST_OK, wait_kind: WK_NONE, value: '0};
          unique case (req_type_i)
            REQ_OP: begin
              op_cnt_d = op_inc;
              if (op_inc > OCW'(MAX_OPS_PER_BATCH)) begin
                state_d = last_op_i ? S_FIN : S_IDLE;
              end else if (!idx_ok) begin
                bad_d   = 1'b1;
                state_d = last_op_i ? S_FIN : S_IDLE;
              end else if (outcome_q == ST_OK) begin
                state_d = S_OP;
              end else begin
                state_d = last_op_i ? S_FIN : S_IDLE;
              end
            end
            REQ_GET: begin
              if (idx_ok) begin
                state_d = S_GET;
              end else begin
                res_d.status = ST_BAD_INDEX;
                state_d = S_EMIT;
              end
            end
            REQ_SET: begin
              if ({1'b0, set_value_i} > SEM_VALUE_MAX) begin
                res_d.status = ST_RANGE;
              end else if (!idx_ok) begin
                res_d.status = ST_BAD_INDEX;
              end else begin
                sem_we = 1'b1;
              end
              state_d = S_EMIT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_OP: begin
        state_d = last_q ? S_FIN : S_IDLE;
        if (delta_q == 16'sd0) begin
          if (cur != '0) begin
            outcome_d = nowait_q ? ST_WOULD_BLOCK : ST_WAIT;
            wk_d      = nowait_q ? wk_q : WK_ZERO;
          end
        end else if (sum[16]) begin
          outcome_d = nowait_q ? ST_WOULD_BLOCK : ST_WAIT;
          wk_d      = nowait_q ? wk_q : WK_INCREASE;
        end else if (sum > $signed(SEM_VALUE_MAX)) begin
          outcome_d = ST_RANGE;
        end else begin
          sh_we = 1'b1;
          if (!sh_rd[VAL_W] && (log_cnt_q < CW'(MAX_SEMS_PER_SET))) begin
            log_we    = 1'b1;
            log_cnt_d = log_cnt_q + 1'b1;
          end
        end
      end
      S_GET: begin
        res_d.value = sem_rd;
        state_d = S_EMIT;
      end
      S_FIN: begin
        commit_d = 1'b0;
        if (op_cnt_q > OCW'(MAX_OPS_PER_BATCH)) begin
          res_d.status = ST_TOO_MANY;
        end else if (bad_q) begin
          res_d.status = ST_BAD_INDEX;
        end else begin
          res_d.status    = outcome_q;
          res_d.wait_kind = (outcome_q == ST_WAIT) ? wk_q : WK_NONE;
          commit_d        = (outcome_q == ST_OK);
        end
        op_cnt_d  = '0;
        outcome_d = ST_OK;
        wk_d      = WK_NONE;
        bad_d     = 1'b0;
        walk_d    = '0;
        state_d   = (log_cnt_q != '0) ? S_WLOG : S_EMIT;
      end
      S_WLOG: begin
        if (walk_q != '0) begin
          // commit write of the previous log entry
          sem_we = commit_q;
          sem_wa = walk_sem_q;
          sem_wd = sh_rd[VAL_W-1:0];
        end
        if (walk_q == log_cnt_q) begin
          log_cnt_d = '0;
          state_d   = S_EMIT;
        end else begin
          state_d = S_WSH;
        end
      end
      S_WSH: begin
        sh_we      = 1'b1;
        sh_wa      = log_rd;
        sh_wd      = '0;
        walk_sem_d = log_rd;
        walk_d     = walk_q + 1'b1;
        state_d    = S_WLOG;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      num_sems_q  <= 10'd1;
      op_cnt_q    <= '0;
      outcome_q   <= ST_OK;
      wk_q        <= WK_NONE;
      bad_q       <= 1'b0;
      commit_q    <= 1'b0;
      log_cnt_q   <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      op_cnt_q  <= op_cnt_d;
      outcome_q <= outcome_d;
      wk_q      <= wk_d;
      bad_q     <= bad_d;
      commit_q  <= commit_d;
      log_cnt_q <= log_cnt_d;
      walk_q    <= walk_d;
      if (num_sems_we_i) begin
        num_sems_q <= num_sems_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    delta_q    <= delta_d;
    nowait_q   <= nowait_d;
    last_q     <= last_d;
    walk_sem_q <= walk_sem_d;
    res_q      <= res_d;
    if (emit) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign wait_kind_o  = out_q.wait_kind;
  assign read_value_o = out_q.value;

endmodule
